>>> design/arcball_rotation_tracker_macros.svh
// assertion macros shared by the arcball rotation tracker
// each macro expects clk and rst in the scope where it is used
`ifndef ARCBALL_ROTATION_TRACKER_MACROS_SVH
`define ARCBALL_ROTATION_TRACKER_MACROS_SVH

// same-cycle implication
`define ARCB_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arcball check failed");

// next-cycle implication
`define ARCB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arcball check failed");

`endif

>>> design/arcb_pkg.sv
// types and constants of the arcball rotation tracker
// used by arcb_iter and arcball_rotation_tracker
package arcb_pkg;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_DRAG  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;
  localparam logic [1:0] CMD_LOAD  = 2'd3;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BALL_RADIUS  = 3'd2;
  localparam logic [2:0] REG_OFFSET_X     = 3'd3;
  localparam logic [2:0] REG_OFFSET_Y     = 3'd4;

  localparam logic [5:0] DIV_LAST  = 6'd63;
  localparam logic [5:0] SQRT_LAST = 6'd31;

  localparam logic signed [15:0] ROT_ONE = 16'sd16384;

  typedef enum logic [0:0] {OP_DIV, OP_SQRT} arcb_op_t;

  typedef struct packed {
    logic        start;
    arcb_op_t    op;
    logic [63:0] a;
    logic [63:0] b;
  } arcb_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } arcb_rsp_t;

  typedef enum logic [2:0] {PH_RWH, PH_MAG, PH_CROSS, PH_NORM, PH_HAM} arcb_phase_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_WAIT,
    ST_BP_DIVX, ST_BP_DIVY, ST_BP_GETY, ST_BP_HALF, ST_BP_CHK,
    ST_BP_NX, ST_BP_NY, ST_BP_NZ, ST_BP_Z, ST_BP_PUT,
    ST_DQ_RND, ST_DQ_SQ, ST_DQ_N, ST_DQ_Q, ST_FIN, ST_DONE
  } arcb_state_t;

endpackage

>>> design/arcb_iter.sv
// shared iterative unit: restoring divide (64 steps) or integer square root (32 steps)
// one 66-bit subtractor serves both; depends on arcb_pkg
module arcb_iter (
  input  logic                clk,
  input  logic                rst,
  input  arcb_pkg::arcb_req_t req,
  output arcb_pkg::arcb_rsp_t rsp
);
  import arcb_pkg::*;

  logic        busy;
  logic        done;
  logic        is_sqrt;
  logic [5:0]  cnt;
  logic [63:0] num;
  logic [63:0] den;
  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] root_try;
  logic [64:0] sub_a;
  logic [64:0] sub_b;
  logic [65:0] diff;
  logic        ge;

  assign root_try = quo + den;

  always_comb begin
    if (is_sqrt) begin
      sub_a = {1'b0, num};
      sub_b = {1'b0, root_try};
    end else begin
      sub_a = {rem, num[63]};
      sub_b = {1'b0, den};
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = !diff[65];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      is_sqrt <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        is_sqrt <= (req.op == OP_SQRT);
        cnt     <= (req.op == OP_SQRT) ? SQRT_LAST : DIV_LAST;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.a;
      den <= (req.op == OP_SQRT) ? (64'd1 << 62) : req.b;
      quo <= '0;
      rem <= '0;
    end else if (busy) begin
      if (is_sqrt) begin
        if (ge) num <= diff[63:0];
        quo <= (quo >> 1) + (ge ? den : 64'd0);
        den <= den >> 2;
      end else begin
        rem <= ge ? diff[63:0] : sub_a[63:0];
        quo <= {quo[62:0], ge};
        num <= num << 1;
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.value = quo;

endmodule

>>> design/arcball_rotation_tracker.sv
// arcball rotation tracker: pointer beats in, rotation quaternion beats out
// depends on arcb_pkg, arcb_iter and arcball_rotation_tracker_macros.svh
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+--------------------------------------------
//  command  | cmd_valid | cmd_stall | cmd, pos_x, pos_y, load_w/x/y/z
//  result   | rot_valid | rot_stall | rot_w, rot_x, rot_y, rot_z, is_dragging
//  config   | cfg_we    | -         | cfg_index, cfg_data
//
// end and load, and a drag with no drag active, go straight to ST_DONE; begin and an
// active drag take longer, set by the shared unit (divide and root) and the pointer
// halving loop. one multiplier does every product, in a multiply and an add state.
// reset gives identity rotation and no drag. cmd_stall is high while a beat is
// worked on; a finished result waits in the output register while rot_stall is high.
`include "arcball_rotation_tracker_macros.svh"

module arcball_rotation_tracker #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  logic [1:0]            cmd,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic signed [15:0]    load_w,
  input  logic signed [15:0]    load_x,
  input  logic signed [15:0]    load_y,
  input  logic signed [15:0]    load_z,
  output logic                  rot_valid,
  input  logic                  rot_stall,
  output logic signed [15:0]    rot_w,
  output logic signed [15:0]    rot_x,
  output logic signed [15:0]    rot_y,
  output logic signed [15:0]    rot_z,
  output logic                  is_dragging
);
  import arcb_pkg::*;

  localparam int MW  = (FRAC_BITS + 4 > 17) ? FRAC_BITS + 4 : 17;
  localparam int AXW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 15;
  localparam logic signed [63:0] ONE2 = 64'sd1 <<< (2 * FRAC_BITS);
  localparam logic [63:0] LIM = 64'd1 << (FRAC_BITS + 1);
  localparam logic signed [MW-1:0] ONE_MW = MW'(64'd1 << FRAC_BITS);

  // configuration
  logic [12:0]        frame_width;
  logic [12:0]        frame_height;
  logic [15:0]        ball_radius;
  logic signed [12:0] center_offset_x;
  logic signed [12:0] center_offset_y;

  // architectural state
  logic signed [15:0]    cur [4];
  logic signed [15:0]    srot [4];
  logic signed [MW-1:0]  sp [3];
  logic                  drag_active;

  // working registers
  arcb_state_t           state, state_next;
  arcb_state_t           wait_ret, mac_ret;
  arcb_phase_t           ph;
  logic [3:0]            t;
  logic [1:0]            g;
  logic [1:0]            k;
  logic                  is_begin;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic [63:0]           ux, uy;
  logic                  sx, sy;
  logic [63:0]           sreg, nreg;
  logic signed [MW-1:0]  pz;
  logic signed [MW-1:0]  tp [3];
  logic signed [MW-1:0]  c [4];
  logic signed [MW-1:0]  q [4];
  logic signed [63:0]    acc, prod;
  logic signed [63:0]    grp [4];

  arcb_req_t req;
  arcb_rsp_t rsp;

  arcb_iter u_iter (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  function automatic logic signed [63:0] shr_round(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    else if (v < -64'sd32768) return -16'sh8000;
    else return 16'(v);
  endfunction

  function automatic logic [MW-1:0] mag_of(input logic signed [MW-1:0] v);
    return v[MW-1] ? MW'(-v) : MW'(v);
  endfunction

  // pointer to ball numerators
  logic [12:0]             weff, heff;
  logic [15:0]             reff;
  logic signed [AXW-1:0]   ax, ay;
  logic [AXW-1:0]          ax_mag, ay_mag;
  logic [63:0]             num_x, num_y;
  logic                    big, big2;

  assign weff = (frame_width == '0) ? 13'd1 : frame_width;
  assign heff = (frame_height == '0) ? 13'd1 : frame_height;
  assign reff = (ball_radius == '0) ? 16'd1 : ball_radius;
  assign ax = ((((AXW'($signed({1'b0, px_r})) - AXW'(center_offset_x)) <<< 1)
              - AXW'($signed({1'b0, weff}))) <<< 12);
  assign ay = ((AXW'($signed({1'b0, heff})) - (AXW'($signed({1'b0, py_r})) <<< 1)
              - (AXW'(center_offset_y) <<< 1)) <<< 12);
  assign ax_mag = ax[AXW-1] ? AXW'(-ax) : AXW'(ax);
  assign ay_mag = ay[AXW-1] ? AXW'(-ay) : AXW'(ay);
  assign num_x = (64'(ax_mag) << FRAC_BITS) + {1'b0, grp[0][63:1]};
  assign num_y = (64'(ay_mag) << FRAC_BITS) + {1'b0, grp[1][63:1]};
  assign big  = (ux >= LIM) || (uy >= LIM);
  assign big2 = grp[0] > ONE2;

  // multiplier operand table
  logic signed [MW-1:0]   ma, mb;
  logic signed [2*MW-1:0] mprod;
  logic                   t_neg, t_last, t_fin;
  logic [1:0]             qi, bi;

  always_comb begin
    ma = '0; mb = '0; t_neg = 1'b0; t_last = 1'b0; t_fin = 1'b0; qi = '0; bi = '0;
    unique case (ph)
      PH_RWH: begin
        ma = MW'($signed({1'b0, reff}));
        mb = t[0] ? MW'($signed({1'b0, heff})) : MW'($signed({1'b0, weff}));
        t_last = 1'b1;
        t_fin = t[0];
      end
      PH_MAG: begin
        ma = t[0] ? $signed(MW'(uy)) : $signed(MW'(ux));
        mb = ma;
        t_last = t[0];
        t_fin = t[0];
      end
      PH_CROSS: begin
        unique case (t)
          4'd0: begin ma = sp[0]; mb = tp[0]; end
          4'd1: begin ma = sp[1]; mb = tp[1]; end
          4'd2: begin ma = sp[2]; mb = tp[2]; t_last = 1'b1; end
          4'd3: begin ma = tp[1]; mb = sp[2]; end
          4'd4: begin ma = tp[2]; mb = sp[1]; t_neg = 1'b1; t_last = 1'b1; end
          4'd5: begin ma = tp[2]; mb = sp[0]; end
          4'd6: begin ma = tp[0]; mb = sp[2]; t_neg = 1'b1; t_last = 1'b1; end
          4'd7: begin ma = tp[0]; mb = sp[1]; end
          default: begin
            ma = tp[1]; mb = sp[0]; t_neg = 1'b1; t_last = 1'b1; t_fin = 1'b1;
          end
        endcase
      end
      PH_NORM: begin
        ma = c[t[1:0]];
        mb = c[t[1:0]];
        t_last = (t[1:0] == 2'd3);
        t_fin = t_last;
      end
      default: begin
        // hamilton product, drag quaternion on the left
        unique case (t)
          4'd0:  begin qi = 2'd0; bi = 2'd0; end
          4'd1:  begin qi = 2'd1; bi = 2'd1; t_neg = 1'b1; end
          4'd2:  begin qi = 2'd2; bi = 2'd2; t_neg = 1'b1; end
          4'd3:  begin qi = 2'd3; bi = 2'd3; t_neg = 1'b1; end
          4'd4:  begin qi = 2'd0; bi = 2'd1; end
          4'd5:  begin qi = 2'd1; bi = 2'd0; end
          4'd6:  begin qi = 2'd2; bi = 2'd3; end
          4'd7:  begin qi = 2'd3; bi = 2'd2; t_neg = 1'b1; end
          4'd8:  begin qi = 2'd0; bi = 2'd2; end
          4'd9:  begin qi = 2'd2; bi = 2'd0; end
          4'd10: begin qi = 2'd3; bi = 2'd1; end
          4'd11: begin qi = 2'd1; bi = 2'd3; t_neg = 1'b1; end
          4'd12: begin qi = 2'd0; bi = 2'd3; end
          4'd13: begin qi = 2'd3; bi = 2'd0; end
          4'd14: begin qi = 2'd1; bi = 2'd2; end
          default: begin qi = 2'd2; bi = 2'd1; t_neg = 1'b1; end
        endcase
        ma = q[qi];
        mb = MW'(srot[bi]);
        t_last = (t[1:0] == 2'd3);
        t_fin = (t == 4'd15);
      end
    endcase
  end

  assign mprod = ma * mb;

  logic signed [63:0] mac_sum;
  assign mac_sum = t_neg ? acc - prod : acc + prod;

  assign cmd_stall = (state != ST_IDLE);

  // next state and shared unit requests
  always_comb begin
    state_next = state;
    req = '0;
    req.op = OP_DIV;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd)
            CMD_BEGIN: state_next = ST_MUL;
            CMD_DRAG:  state_next = drag_active ? ST_MUL : ST_DONE;
            CMD_END:   state_next = ST_DONE;
            CMD_LOAD:  state_next = ST_DONE;
          endcase
        end
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = t_fin ? mac_ret : ST_MUL;
      ST_WAIT: if (rsp.done) state_next = wait_ret;
      ST_BP_DIVX: begin
        req.start = 1'b1; req.a = num_x; req.b = grp[0];
        state_next = ST_WAIT;
      end
      ST_BP_DIVY: begin
        req.start = 1'b1; req.a = num_y; req.b = grp[1];
        state_next = ST_WAIT;
      end
      ST_BP_GETY: state_next = ST_BP_HALF;
      ST_BP_HALF: if (!big) state_next = ST_MUL;
      ST_BP_CHK: begin
        req.start = 1'b1; req.op = OP_SQRT;
        req.a = big2 ? 64'(grp[0]) : 64'(ONE2 - grp[0]);
        state_next = ST_WAIT;
      end
      ST_BP_NX: begin
        req.start = 1'b1;
        req.a = (ux << FRAC_BITS) + (rsp.value >> 1);
        req.b = rsp.value;
        state_next = ST_WAIT;
      end
      ST_BP_NY: begin
        req.start = 1'b1;
        req.a = (uy << FRAC_BITS) + (sreg >> 1);
        req.b = sreg;
        state_next = ST_WAIT;
      end
      ST_BP_NZ: state_next = ST_BP_PUT;
      ST_BP_Z:  state_next = ST_BP_PUT;
      ST_BP_PUT: state_next = is_begin ? ST_DONE : ST_MUL;
      ST_DQ_RND: state_next = ST_MUL;
      ST_DQ_SQ: begin
        req.start = 1'b1; req.op = OP_SQRT; req.a = 64'(grp[0]);
        state_next = ST_WAIT;
      end
      ST_DQ_N: begin
        if (rsp.value == '0) begin
          state_next = ST_MUL;
        end else begin
          req.start = 1'b1;
          req.a = (64'(mag_of(c[0])) << FRAC_BITS) + (rsp.value >> 1);
          req.b = rsp.value;
          state_next = ST_WAIT;
        end
      end
      ST_DQ_Q: begin
        if (k == 2'd3) begin
          state_next = ST_MUL;
        end else begin
          req.start = 1'b1;
          req.a = (64'(mag_of(c[k + 2'd1])) << FRAC_BITS) + (nreg >> 1);
          req.b = nreg;
          state_next = ST_WAIT;
        end
      end
      ST_FIN: state_next = ST_DONE;
      ST_DONE: if (!rot_valid || !rot_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= 13'd1024;
      frame_height    <= 13'd1024;
      ball_radius     <= 16'd4096;
      center_offset_x <= '0;
      center_offset_y <= '0;
      for (int i = 0; i < 4; i++) begin
        cur[i]  <= (i == 0) ? ROT_ONE : '0;
        srot[i] <= (i == 0) ? ROT_ONE : '0;
      end
      for (int i = 0; i < 3; i++) sp[i] <= '0;
      drag_active <= 1'b0;
      rot_valid   <= 1'b0;
      wait_ret    <= ST_IDLE;
      mac_ret     <= ST_IDLE;
      ph          <= PH_RWH;
      t           <= '0;
      g           <= '0;
      k           <= '0;
      is_begin    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width     <= cfg_data[12:0];
          REG_FRAME_HEIGHT: frame_height    <= cfg_data[12:0];
          REG_BALL_RADIUS:  ball_radius     <= cfg_data;
          REG_OFFSET_X:     center_offset_x <= $signed(cfg_data[12:0]);
          REG_OFFSET_Y:     center_offset_y <= $signed(cfg_data[12:0]);
          default: ;
        endcase
      end

      if (state == ST_DONE && (!rot_valid || !rot_stall)) rot_valid <= 1'b1;
      else if (rot_valid && !rot_stall) rot_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            px_r     <= pos_x;
            py_r     <= pos_y;
            is_begin <= (cmd == CMD_BEGIN);
            ph       <= PH_RWH;
            t        <= '0;
            g        <= '0;
            acc      <= '0;
            mac_ret  <= ST_BP_DIVX;
            unique case (cmd)
              CMD_BEGIN: begin
                srot        <= cur;
                drag_active <= 1'b1;
              end
              CMD_DRAG: ;
              CMD_END: drag_active <= 1'b0;
              CMD_LOAD: begin
                drag_active <= 1'b0;
                cur[0] <= load_w;
                cur[1] <= load_x;
                cur[2] <= load_y;
                cur[3] <= load_z;
              end
            endcase
          end
        end
        ST_MUL: prod <= 64'(mprod);
        ST_ADD: begin
          if (t_last) begin
            grp[g] <= mac_sum;
            acc    <= '0;
            g      <= g + 2'd1;
          end else begin
            acc <= mac_sum;
          end
          t <= t + 4'd1;
        end
        ST_BP_DIVX: begin
          sx       <= ax[AXW-1];
          wait_ret <= ST_BP_DIVY;
        end
        ST_BP_DIVY: begin
          ux       <= rsp.value;
          sy       <= ay[AXW-1];
          wait_ret <= ST_BP_GETY;
        end
        ST_BP_GETY: uy <= rsp.value;
        ST_BP_HALF: begin
          if (big) begin
            ux <= ux >> 1;
            uy <= uy >> 1;
          end else begin
            ph <= PH_MAG; t <= '0; g <= '0; acc <= '0; mac_ret <= ST_BP_CHK;
          end
        end
        ST_BP_CHK: wait_ret <= big2 ? ST_BP_NX : ST_BP_Z;
        ST_BP_NX: begin
          sreg     <= rsp.value;
          wait_ret <= ST_BP_NY;
        end
        ST_BP_NY: begin
          ux       <= rsp.value;
          wait_ret <= ST_BP_NZ;
        end
        ST_BP_NZ: begin
          uy <= rsp.value;
          pz <= '0;
        end
        ST_BP_Z: pz <= $signed(MW'(rsp.value));
        ST_BP_PUT: begin
          if (is_begin) begin
            sp[0] <= sx ? -$signed(MW'(ux)) : $signed(MW'(ux));
            sp[1] <= sy ? -$signed(MW'(uy)) : $signed(MW'(uy));
            sp[2] <= pz;
          end else begin
            tp[0] <= sx ? -$signed(MW'(ux)) : $signed(MW'(ux));
            tp[1] <= sy ? -$signed(MW'(uy)) : $signed(MW'(uy));
            tp[2] <= pz;
            ph <= PH_CROSS; t <= '0; g <= '0; acc <= '0; mac_ret <= ST_DQ_RND;
          end
        end
        ST_DQ_RND: begin
          for (int i = 0; i < 4; i++) c[i] <= MW'(shr_round(grp[i]));
          ph <= PH_NORM; t <= '0; g <= '0; acc <= '0; mac_ret <= ST_DQ_SQ;
        end
        ST_DQ_SQ: wait_ret <= ST_DQ_N;
        ST_DQ_N: begin
          nreg <= rsp.value;
          k    <= '0;
          if (rsp.value == '0) begin
            // zero norm: no defined axis, keep the start rotation
            q[0] <= ONE_MW;
            q[1] <= '0;
            q[2] <= '0;
            q[3] <= '0;
            ph <= PH_HAM; t <= '0; g <= '0; acc <= '0; mac_ret <= ST_FIN;
          end else begin
            wait_ret <= ST_DQ_Q;
          end
        end
        ST_DQ_Q: begin
          q[k] <= c[k][MW-1] ? -$signed(MW'(rsp.value)) : $signed(MW'(rsp.value));
          if (k == 2'd3) begin
            ph <= PH_HAM; t <= '0; g <= '0; acc <= '0; mac_ret <= ST_FIN;
          end else begin
            k        <= k + 2'd1;
            wait_ret <= ST_DQ_Q;
          end
        end
        ST_FIN: begin
          for (int i = 0; i < 4; i++) cur[i] <= sat16(shr_round(grp[i]));
        end
        ST_DONE: begin
          if (!rot_valid || !rot_stall) begin
            rot_w       <= cur[0];
            rot_x       <= cur[1];
            rot_y       <= cur[2];
            rot_z       <= cur[3];
            is_dragging <= drag_active;
          end
        end
        default: ;
      endcase
    end
  end

  `ARCB_ASSERT_NOW(a_done_in_wait, rsp.done, state == ST_WAIT)
  `ARCB_ASSERT_NEXT(a_begin_sets_drag, cmd_valid && !cmd_stall && cmd == CMD_BEGIN, drag_active)
  `ARCB_ASSERT_NEXT(a_load_ends_drag, cmd_valid && !cmd_stall && cmd == CMD_LOAD, !drag_active)
  `ARCB_ASSERT_NOW(a_norm_nonzero, state == ST_DQ_Q, nreg != '0)

endmodule
